// ----- rtl/sphere_box_classify_macros.svh -----
// Assertion macros for the sphere/box classifier.
// Included by sphere_box_classify.sv; no other dependencies.
`ifndef SPHERE_BOX_CLASSIFY_MACROS_SVH
`define SPHERE_BOX_CLASSIFY_MACROS_SVH

// implication checked every cycle outside reset
`define SBC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sphere_box_classify: assertion failed");

// combinational condition that must hold whenever the guard is high
`define SBC_ASSERT_WHEN(label, clk, rst_n, guard, cond) \
  `SBC_ASSERT(label, clk, rst_n, (guard) |-> (cond))

`endif

// ----- rtl/sbc_pkg.sv -----
// Shared constants for the sphere/box classifier: widths, register
// indexes and result codes. No dependencies.
`default_nettype none
package sbc_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST     = 3'd4;

  localparam int REL_W = 2;
  localparam logic [REL_W-1:0] REL_OUTSIDE    = 2'd0;
  localparam logic [REL_W-1:0] REL_INTERSECTS = 2'd1;
  localparam logic [REL_W-1:0] REL_INSIDE     = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/sphere_box_classify.sv -----
// Sphere versus axis-aligned box classifier, five-stage pipeline.
// Each box passes stages 1 to 5 with its valid in v1_r to v5_r; out_valid is
// v5_r, and the relation is registered in rel_r.
// Throughput: one box per cycle; busy stays low, the receiver cannot stall.
// The six per-axis squares set the stage-3 depth; radius square is registered apart.
// Reset (rst_n low, synchronous) clears the pipeline valids and all
// configuration registers to zero.
`default_nettype none
`include "sphere_box_classify_macros.svh"
module sphere_box_classify
  import sbc_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  signed [COORD_WIDTH-1:0] in_box_min_x,
  input  wire  signed [COORD_WIDTH-1:0] in_box_min_y,
  input  wire  signed [COORD_WIDTH-1:0] in_box_min_z,
  input  wire  signed [COORD_WIDTH-1:0] in_box_max_x,
  input  wire  signed [COORD_WIDTH-1:0] in_box_max_y,
  input  wire  signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                         out_valid,
  output logic [REL_W-1:0]             out_relation,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [CFG_IDX_W-1:0]         cfg_index,
  input  wire  [COORD_WIDTH-1:0]       cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int SQW  = 2 * DW;
  localparam int SUMW = SQW + 2;
  localparam int RW   = CW - 1;
  localparam int R2W  = 2 * RW;

  // configuration
  logic signed [CW-1:0] ctr_r [3];
  logic [RW-1:0]        radius_r;
  logic                 fast_r;
  logic [R2W-1:0]       r2_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      radius_r <= '0;
      fast_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X: ctr_r[0] <= cfg_data;
        CFG_CENTER_Y: ctr_r[1] <= cfg_data;
        CFG_CENTER_Z: ctr_r[2] <= cfg_data;
        CFG_RADIUS:   radius_r <= cfg_data[RW-1:0];
        CFG_FAST:     fast_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= R2W'(radius_r) * R2W'(radius_r);
  end

  logic signed [CW-1:0] box_lo [3];
  logic signed [CW-1:0] box_hi [3];

  assign box_lo[0] = in_box_min_x;
  assign box_lo[1] = in_box_min_y;
  assign box_lo[2] = in_box_min_z;
  assign box_hi[0] = in_box_max_x;
  assign box_hi[1] = in_box_max_y;
  assign box_hi[2] = in_box_max_z;

  logic in_accept;
  assign in_accept = start && !busy;

  // valid chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: offsets of the interval ends from the center
  logic signed [DW-1:0] dlo_r [3];
  logic signed [DW-1:0] dhi_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dlo_r[i] <= DW'(box_lo[i]) - DW'(ctr_r[i]);
      dhi_r[i] <= DW'(box_hi[i]) - DW'(ctr_r[i]);
    end
  end

  // stage 2: gap and far magnitudes per axis
  logic [DW-1:0] mlo      [3];
  logic [DW-1:0] mhi      [3];
  logic [DW-1:0] gap_nxt  [3];
  logic [DW-1:0] far_nxt  [3];
  logic [DW-1:0] gap_m_r  [3];
  logic [DW-1:0] far_m_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mlo[i] = dlo_r[i][DW-1] ? DW'(-dlo_r[i]) : DW'(dlo_r[i]);
      mhi[i] = dhi_r[i][DW-1] ? DW'(-dhi_r[i]) : DW'(dhi_r[i]);
      // center below the minimum first, then above the maximum
      if (!dlo_r[i][DW-1] && (dlo_r[i] != '0)) begin
        gap_nxt[i] = mlo[i];
      end else if (dhi_r[i][DW-1]) begin
        gap_nxt[i] = mhi[i];
      end else begin
        gap_nxt[i] = '0;
      end
      far_nxt[i] = (mlo[i] > mhi[i]) ? mlo[i] : mhi[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      gap_m_r[i] <= gap_nxt[i];
      far_m_r[i] <= far_nxt[i];
    end
  end

  // stage 3: squares
  logic [SQW-1:0] gap_sq_r [3];
  logic [SQW-1:0] far_sq_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      gap_sq_r[i] <= SQW'(gap_m_r[i]) * SQW'(gap_m_r[i]);
      far_sq_r[i] <= SQW'(far_m_r[i]) * SQW'(far_m_r[i]);
    end
  end

  // stage 4: sums
  logic [SUMW-1:0] gap_sum_r;
  logic [SUMW-1:0] far_sum_r;

  always_ff @(posedge clk) begin
    gap_sum_r <= SUMW'(gap_sq_r[0]) + SUMW'(gap_sq_r[1]) + SUMW'(gap_sq_r[2]);
    far_sum_r <= SUMW'(far_sq_r[0]) + SUMW'(far_sq_r[1]) + SUMW'(far_sq_r[2]);
  end

  // stage 5: compare against the squared radius
  logic [REL_W-1:0] rel_nxt;
  logic [REL_W-1:0] rel_r;

  always_comb begin
    priority if (gap_sum_r >= SUMW'(r2_r)) begin
      rel_nxt = REL_OUTSIDE;
    end else if (fast_r) begin
      rel_nxt = REL_INSIDE;
    end else if (far_sum_r >= SUMW'(r2_r)) begin
      rel_nxt = REL_INTERSECTS;
    end else begin
      rel_nxt = REL_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    rel_r <= rel_nxt;
  end

  assign out_valid    = v5_r;
  assign out_relation = rel_r;

  `SBC_ASSERT(a_latency, clk, rst_n, in_accept |-> ##5 out_valid)
  `SBC_ASSERT_WHEN(a_fast_no_isect, clk, rst_n, out_valid && fast_r, out_relation != REL_INTERSECTS)
  `SBC_ASSERT_WHEN(a_rel_code, clk, rst_n, out_valid, out_relation <= REL_INSIDE)

endmodule
`default_nettype wire

// ----- bench/sphere_box_classify_tb.sv -----
// Self-checking bench for sphere_box_classify: directed and random boxes against
// several sphere settings, each relation checked against a local classifier.
// Depends on sbc_pkg and the sphere_box_classify RTL.
`timescale 1ns / 1ps
module sphere_box_classify_tb;
  import sbc_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
  localparam longint RADIUS_MAX = COORD_MAX;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  class sphere_scoreboard;
    longint ctr[3] = '{0, 0, 0};
    longint radius = 0;
    bit fast = 1'b0;
    logic [REL_W-1:0] expected_rel[$];
    int mismatches = 0;
    int boxes = 0;
    int checked = 0;
    int rel_count[3] = '{0, 0, 0};

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
      case (idx)
        CFG_CENTER_X: ctr[0] = $signed(data);
        CFG_CENTER_Y: ctr[1] = $signed(data);
        CFG_CENTER_Z: ctr[2] = $signed(data);
        CFG_RADIUS: radius = data[CW-2:0];
        CFG_FAST: fast = data[0];
        default: ;
      endcase
    endfunction

    function logic [REL_W-1:0] classify(box_t b);
      longint l, h, dl, dh, gap, far, r2;
      gap = 0;
      far = 0;
      for (int i = 0; i < 3; i++) begin
        l = $signed(b.lo[i]);
        h = $signed(b.hi[i]);
        dl = (l - ctr[i]) * (l - ctr[i]);
        dh = (h - ctr[i]) * (h - ctr[i]);
        if (ctr[i] < l) gap += dl;
        else if (ctr[i] > h) gap += dh;
        far += (dl > dh) ? dl : dh;
      end
      r2 = radius * radius;
      if (gap >= r2) return REL_OUTSIDE;
      if (fast) return REL_INSIDE;
      return (far >= r2) ? REL_INTERSECTS : REL_INSIDE;
    endfunction

    function void note_box(box_t b);
      logic [REL_W-1:0] rel;
      rel = classify(b);
      expected_rel.push_back(rel);
      rel_count[rel]++;
      boxes++;
    endfunction

    function void check_result(logic [REL_W-1:0] rel);
      logic [REL_W-1:0] want;
      if (expected_rel.size() == 0) begin
        if (mismatches < 10) $display("ERROR: relation %0d with no box pending", rel);
        mismatches++;
        return;
      end
      want = expected_rel.pop_front();
      checked++;
      if (rel !== want) begin
        if (mismatches < 10)
          $display("ERROR: result %0d relation expected %0d got %0d", checked, want, rel);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  box_t box_drv = '0;
  logic out_valid;
  logic [REL_W-1:0] out_relation;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  sphere_scoreboard sb = new;

  always #5 clk = ~clk;

  sphere_box_classify dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_box_min_x(box_drv.lo[0]),
    .in_box_min_y(box_drv.lo[1]),
    .in_box_min_z(box_drv.lo[2]),
    .in_box_max_x(box_drv.hi[0]),
    .in_box_max_y(box_drv.hi[1]),
    .in_box_max_z(box_drv.hi[2]),
    .out_valid(out_valid),
    .out_relation(out_relation),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_box(box_drv);
      if (out_valid) sb.check_result(out_relation);
    end
  end

  function automatic logic [CW-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[CW-1:0];
  endfunction

  function automatic box_t mk_box(longint lx, longint ly, longint lz,
                                  longint hx, longint hy, longint hz);
    box_t b;
    b.lo[0] = clamp_coord(lx);
    b.lo[1] = clamp_coord(ly);
    b.lo[2] = clamp_coord(lz);
    b.hi[0] = clamp_coord(hx);
    b.hi[1] = clamp_coord(hy);
    b.hi[2] = clamp_coord(hz);
    return b;
  endfunction

  function automatic longint rnd_offset(longint span);
    return longint'($urandom_range(0, int'(2 * span))) - span;
  endfunction

  // mostly boxes around the sphere, some tight inner boxes, inverted ones, raw noise
  function automatic box_t gen_box();
    box_t b;
    logic [CW-1:0] t;
    longint a, e, r;
    int kind;
    kind = $urandom_range(0, 99);
    r = sb.radius;
    for (int i = 0; i < 3; i++) begin
      if (kind < 60 || kind >= 80) begin
        a = sb.ctr[i] + rnd_offset(2 * r + 64);
        e = a + longint'($urandom_range(0, int'(r + 64)));
      end else begin
        a = sb.ctr[i] + rnd_offset(r / 4);
        e = a + longint'($urandom_range(0, int'(r / 4)));
      end
      b.lo[i] = clamp_coord(a);
      b.hi[i] = clamp_coord(e);
      if (kind >= 80 && kind < 92) begin
        t = b.lo[i];
        b.lo[i] = b.hi[i];
        b.hi[i] = t;
      end
    end
    if (kind >= 92) b = BOX_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return b;
  endfunction

  task automatic send_box(box_t b, int gap_pct);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    box_drv <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.expected_rel.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    if ($urandom_range(0, 3) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // spare bits above each register width are randomized; they must be ignored
  task automatic program_sphere(longint cx, longint cy, longint cz, longint r, bit fm);
    logic [CW-1:0] d;
    cfg_put(CFG_CENTER_X, cx[CW-1:0]);
    cfg_put(CFG_CENTER_Y, cy[CW-1:0]);
    cfg_put(CFG_CENTER_Z, cz[CW-1:0]);
    d = r[CW-1:0];
    d[CW-1] = 1'($urandom_range(0, 1));
    cfg_put(CFG_RADIUS, d);
    d = CW'($urandom);
    d[0] = fm;
    cfg_put(CFG_FAST, d);
    cfg_put(CFG_IDX_W'($urandom_range(int'(CFG_FAST) + 1, int'(CFG_IDX_LAST))),
            CW'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_directed_core(int gap_pct);
    send_box(mk_box(-256, -256, -256, 256, 256, 256), gap_pct);
    send_box(mk_box(-5120, -5120, -5120, 5120, 5120, 5120), gap_pct);
    send_box(mk_box(3000, 3000, 3000, 4000, 4000, 4000), gap_pct);
    send_box(mk_box(2560, -10, -10, 3000, 10, 10), gap_pct);
    send_box(mk_box(2559, -10, -10, 3000, 10, 10), gap_pct);
    send_box(mk_box(100, 100, 100, -100, -100, -100), gap_pct);
    send_box(mk_box(3000, -10, -10, -3000, 10, 10), gap_pct);
    send_box(mk_box(0, 0, 0, 2560, 0, 0), gap_pct);
  endtask

  initial begin
    longint r;
    bit fm;
    int gap_pct;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: zero radius, everything outside
    send_box(mk_box(0, 0, 0, 0, 0, 0), 30);
    send_box(mk_box(-10, -10, -10, 10, 10, 10), 30);
    wait_idle();

    program_sphere(0, 0, 0, 2560, 1'b0);
    send_directed_core(30);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 30);
    send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 30);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), 30);
    wait_idle();

    program_sphere(0, 0, 0, 2560, 1'b1);
    send_directed_core(30);
    wait_idle();

    program_sphere(COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX, 1'b0);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), 30);
    send_box(mk_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX), 30);
    send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 30);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: r = $urandom_range(1, 4095);
        1: r = $urandom_range(4096, 1 << 20);
        default: r = $urandom_range(1 << 20, int'(RADIUS_MAX));
      endcase
      if (p == 5) r = RADIUS_MAX;
      fm = p[0];
      gap_pct = (p == 5) ? 0 : ((p == 3) ? 10 : 35);
      if (p % 2 == 0)
        program_sphere(rnd_offset(1 << 16), rnd_offset(1 << 16), rnd_offset(1 << 16), r, fm);
      else
        program_sphere(longint'($signed(CW'($urandom))), longint'($signed(CW'($urandom))),
                       longint'($signed(CW'($urandom))), r, fm);
      for (int n = 0; n < 63; n++) send_box(gen_box(), gap_pct);
      wait_idle();
    end

    $display("boxes sent %0d, results checked %0d, left pending %0d",
             sb.boxes, sb.checked, sb.expected_rel.size());
    $display("expected mix: outside %0d, intersecting %0d, inside %0d",
             sb.rel_count[REL_OUTSIDE], sb.rel_count[REL_INTERSECTS], sb.rel_count[REL_INSIDE]);
    if (sb.mismatches == 0 && sb.expected_rel.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sbc_pkg.sv
rtl/sphere_box_classify.sv
bench/sphere_box_classify_tb.sv
